// ----- src/mbp_pkg.sv -----
// Shared types and constants of the mirror border padder.
`timescale 1ns / 1ps

package mbp_pkg;

	localparam int MAX_ROWS    = 128;
	localparam int MAX_COLS    = 128;
	localparam int MAX_BORDER  = 16;
	localparam int DIM_W       = 8;
	localparam int BORDER_W    = 5;
	localparam int CHAN_W      = 8;
	localparam int PIX_W       = 3 * CHAN_W;
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int COL_W       = $clog2(MAX_COLS);
	localparam int ADDR_W      = ROW_W + COL_W;
	localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEIGHT = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_BORDER = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_READ  = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		logic              action;
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] blue_out;
		logic [DIM_W-1:0]  padded_row;
		logic [DIM_W-1:0]  padded_col;
		logic              frame_last;
		logic              border_error;
	} out_item_t;

	// One frame store operation, in item order, between front and back.
	typedef struct packed {
		cmd_kind_t         kind;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  pix;
		logic [DIM_W-1:0]  row;
		logic [DIM_W-1:0]  col;
		logic              last;
		logic              err;
	} cmd_t;

endpackage

// ----- src/mirror_border_padder.sv -----
// Top level of the mirror border padder: frame store with mirrored read-out.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------
//  cfg     | cfg_valid, cfg_ready | cfg_index (register), cfg_data
//  in      | in_valid, in_ready   | in_data: action, red/green/blue_in
//  out     | out_valid, out_ready | out_data: pixel, padded_row/col, flags
//
// Throughput is one item per cycle while the queue is not full: each load or
// request is a single access to the single-port frame store in the back part.
// A request's result passes through the command queue, the registered RAM
// read and the output register before it is valid.
// Reset clears the positions, the queue and the output register, and loads
// the registers with height 128, width 128, border 0; the frame store holds
// no reset value and needs no clearing pass.
// A stalled output fills the read stage and then the four-entry queue; only
// then does in_ready drop. cfg_ready is always high.
`timescale 1ns / 1ps

module mirror_border_padder import mbp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data
);

	logic q_full;
	logic q_push;
	cmd_t q_push_cmd;
	logic q_pop;
	logic q_valid;
	cmd_t q_cmd;

	// Accept register writes at any time; each takes effect at once and restarts
	// the positions, so write only while no item is in flight.
	assign cfg_ready = 1'b1;

	// Front: classify each item, track positions, map padded to source address.
	mbp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (q_push),
		.cmd      (q_push_cmd)
	);

	// Queue: hold store writes and reads in item order, decoupling front and back until it fills.
	mbp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_valid(q_valid),
		.pop_cmd  (q_cmd)
	);

	// Back: perform the store access and drive the output register.
	mbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

// ----- src/mbp_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module mbp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/mbp_queue.sv -----
// Short command queue between the front and back of the padder.
`timescale 1ns / 1ps

module mbp_queue import mbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output cmd_t pop_cmd
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd   = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

`ifndef SYNTHESIS
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

// ----- src/mbp_front.sv -----
// Front part: configuration, load and emit positions, mirror address mapping.
`timescale 1ns / 1ps

module mbp_front import mbp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	input  logic                  q_full,
	output logic                  push,
	output cmd_t                  cmd
);

	logic [DIM_W-1:0]    height_q;
	logic [DIM_W-1:0]    width_q;
	logic [BORDER_W-1:0] border_q;
	logic [ROW_W-1:0]    load_row_q;
	logic [COL_W-1:0]    load_col_q;
	logic [DIM_W-1:0]    emit_row_q;
	logic [DIM_W-1:0]    emit_col_q;

	logic [DIM_W-1:0]    rows_eff;
	logic [DIM_W-1:0]    cols_eff;
	logic [BORDER_W-1:0] b_eff;
	logic [DIM_W-1:0]    b_ext;
	logic [DIM_W-1:0]    prow;
	logic [DIM_W-1:0]    pcol;
	logic                err;
	logic [DIM_W-1:0]    er;
	logic [DIM_W-1:0]    ec;
	logic [DIM_W-1:0]    sr;
	logic [DIM_W-1:0]    sc;
	logic                in_fire;
	logic                cfg_hit;
	logic                load_in_range;
	logic [DIM_W-1:0]    load_col_inc;
	logic [DIM_W-1:0]    load_row_inc;
	logic [DIM_W-1:0]    ec_inc;
	logic [DIM_W-1:0]    er_inc;

	// Reflect a padded position into the source range, edge pixel included.
	function automatic logic [DIM_W-1:0] reflect_pos(input logic [DIM_W-1:0] p,
		input logic [DIM_W-1:0] b, input logic [DIM_W-1:0] size);
		logic [DIM_W:0] t;
		logic [DIM_W:0] r;
		t = {1'b0, p} - {1'b0, b};
		if (p < b) begin
			r = {1'b0, b} - {1'b0, p} - (DIM_W+1)'(1);
		end else if (t >= {1'b0, size}) begin
			r = {size, 1'b0} - (DIM_W+1)'(1) - t;
		end else begin
			r = t;
		end
		return r[DIM_W-1:0];
	endfunction

	always_comb begin
		if (height_q == '0) begin
			rows_eff = DIM_W'(1);
		end else if (height_q > DIM_W'(MAX_ROWS)) begin
			rows_eff = DIM_W'(MAX_ROWS);
		end else begin
			rows_eff = height_q;
		end
		if (width_q == '0) begin
			cols_eff = DIM_W'(1);
		end else if (width_q > DIM_W'(MAX_COLS)) begin
			cols_eff = DIM_W'(MAX_COLS);
		end else begin
			cols_eff = width_q;
		end
		b_eff = (border_q > BORDER_W'(MAX_BORDER)) ? BORDER_W'(MAX_BORDER) : border_q;
	end

	assign b_ext = DIM_W'(b_eff);
	assign prow  = rows_eff + DIM_W'({b_eff, 1'b0});
	assign pcol  = cols_eff + DIM_W'({b_eff, 1'b0});
	assign err   = (b_ext > rows_eff) || (b_ext > cols_eff);

	// Restart the walk when a stale position lies outside the padded frame.
	always_comb begin
		if (emit_row_q >= prow || emit_col_q >= pcol) begin
			er = '0;
			ec = '0;
		end else begin
			er = emit_row_q;
			ec = emit_col_q;
		end
	end

	assign sr = reflect_pos(er, b_ext, rows_eff);
	assign sc = reflect_pos(ec, b_ext, cols_eff);

	assign in_ready      = !q_full;
	assign in_fire       = in_valid && in_ready;
	assign load_in_range = ({1'b0, load_row_q} < rows_eff) && ({1'b0, load_col_q} < cols_eff);
	assign load_col_inc  = DIM_W'(load_col_q) + DIM_W'(1);
	assign load_row_inc  = DIM_W'(load_row_q) + DIM_W'(1);
	assign ec_inc        = ec + DIM_W'(1);
	assign er_inc        = er + DIM_W'(1);

	always_comb begin
		cmd.row  = er;
		cmd.col  = ec;
		cmd.last = (er == prow - DIM_W'(1)) && (ec == pcol - DIM_W'(1));
		cmd.err  = err;
		cmd.pix  = {in_data.red_in, in_data.green_in, in_data.blue_in};
		if (in_data.action) begin
			cmd.kind = CMD_READ;
			cmd.addr = {sr[ROW_W-1:0], sc[COL_W-1:0]};
		end else begin
			cmd.kind = CMD_WRITE;
			cmd.addr = {load_row_q, load_col_q};
		end
	end

	assign push = in_fire && (in_data.action || load_in_range);

	always_comb begin
		case (cfg_index)
			REG_HEIGHT, REG_WIDTH, REG_BORDER: cfg_hit = cfg_valid;
			default:                           cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q   <= DIM_W'(128);
			width_q    <= DIM_W'(128);
			border_q   <= '0;
			load_row_q <= '0;
			load_col_q <= '0;
			emit_row_q <= '0;
			emit_col_q <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_HEIGHT: height_q <= cfg_data;
				REG_WIDTH:  width_q  <= cfg_data;
				REG_BORDER: border_q <= cfg_data[BORDER_W-1:0];
				default:    ;
			endcase
			load_row_q <= '0;
			load_col_q <= '0;
			emit_row_q <= '0;
			emit_col_q <= '0;
		end else if (in_fire) begin
			if (!in_data.action) begin
				if (load_col_inc >= cols_eff) begin
					load_col_q <= '0;
					load_row_q <= (load_row_inc >= rows_eff) ? '0 : load_row_inc[ROW_W-1:0];
				end else begin
					load_col_q <= load_col_inc[COL_W-1:0];
				end
			end else begin
				if (ec_inc >= pcol) begin
					emit_col_q <= '0;
					emit_row_q <= (er_inc >= prow) ? '0 : er_inc;
				end else begin
					emit_col_q <= ec_inc;
					emit_row_q <= er;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_read_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cmd.kind == CMD_READ && !cmd.err) |->
		({1'b0, cmd.addr[ADDR_W-1 -: ROW_W]} < rows_eff &&
		{1'b0, cmd.addr[COL_W-1:0]} < cols_eff))
		else $error("mirror address outside source frame");
`endif

endmodule

// ----- src/mbp_back.sv -----
// Back part: frame store access and the output register.
`timescale 1ns / 1ps

module mbp_back import mbp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  cmd_t      q_cmd,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic             s1_valid_q;
	logic [DIM_W-1:0] row_s1;
	logic [DIM_W-1:0] col_s1;
	logic             last_s1;
	logic             err_s1;
	logic             out_valid_q;
	out_item_t        out_q;
	logic             s1_adv;
	logic             rd_pop;
	logic             wr_pop;
	logic [PIX_W-1:0] rd_data;
	logic [PIX_W-1:0] pix;

	assign s1_adv = s1_valid_q && (!out_valid_q || out_ready);
	assign q_pop  = q_valid && (q_cmd.kind == CMD_WRITE || !s1_valid_q || s1_adv);
	assign rd_pop = q_pop && (q_cmd.kind == CMD_READ);
	assign wr_pop = q_pop && (q_cmd.kind == CMD_WRITE);

	mbp_ram #(
		.WIDTH(PIX_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_pop),
		.re   (rd_pop),
		.addr (q_cmd.addr),
		.wdata(q_cmd.pix),
		.rdata(rd_data)
	);

	assign pix = err_s1 ? '0 : rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_pop) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pop) begin
			row_s1  <= q_cmd.row;
			col_s1  <= q_cmd.col;
			last_s1 <= q_cmd.last;
			err_s1  <= q_cmd.err;
		end
		if (s1_adv) begin
			out_q.red_out      <= pix[PIX_W-1 -: CHAN_W];
			out_q.green_out    <= pix[CHAN_W +: CHAN_W];
			out_q.blue_out     <= pix[CHAN_W-1:0];
			out_q.padded_row   <= row_s1;
			out_q.padded_col   <= col_s1;
			out_q.frame_last   <= last_s1;
			out_q.border_error <= err_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_read_data_held: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(rd_data)))
		else $error("read data lost while waiting for the output register");

	a_error_pixel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.border_error) |->
		(out_q.red_out == '0 && out_q.green_out == '0 && out_q.blue_out == '0))
		else $error("border error with nonzero pixel");
`endif

endmodule
